// ===== sv/mdenc_pkg.sv =====
package mdenc_pkg;

  localparam int unsigned MaxBytes = 6;
  localparam int unsigned IdxW = $clog2(MaxBytes);
  localparam int unsigned CntW = $clog2(MaxBytes + 1);
  localparam int unsigned Septets = 5;

  // event kinds
  localparam logic [2:0] MODE_NOTE_OFF = 3'd0;
  localparam logic [2:0] MODE_NOTE_ON  = 3'd1;
  localparam logic [2:0] MODE_CONTROL  = 3'd2;
  localparam logic [2:0] MODE_PROGRAM  = 3'd3;
  localparam logic [2:0] MODE_PITCH    = 3'd4;
  localparam logic [2:0] MODE_TEMPO    = 3'd5;
  localparam logic [2:0] MODE_VARLEN   = 3'd6;
  localparam logic [2:0] MODE_UNUSED   = 3'd7;

  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_CONTROL  = 8'hB0;
  localparam logic [7:0] STATUS_PROGRAM  = 8'hC0;
  localparam logic [7:0] STATUS_PITCH    = 8'hE0;
  localparam logic [7:0] META_PREFIX     = 8'hFF;
  localparam logic [7:0] TEMPO_TYPE      = 8'h51;
  localparam logic [7:0] TEMPO_LEN       = 8'h03;
  localparam logic       CONT_BIT        = 1'b1;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
  } event_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== sv/mdenc_front.sv =====
module mdenc_front (
  input  logic                   start,
  input  logic                   full,
  input  logic [2:0]             mode,
  input  logic [3:0]             channel,
  input  logic [6:0]             data_key,
  input  logic [31:0]            data_value,
  output logic                   push,
  output mdenc_pkg::event_t      ev
);

  logic [mdenc_pkg::Septets-1:0][6:0] sept;
  logic [2:0]                         n_sept;
  logic [2:0]                         pos;
  logic                               known;

  // septets of the variable-length value, least significant first
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sept[i] = data_value[7*i +: 7];
    end
    sept[4] = {3'b000, data_value[31:28]};
    if (sept[4] != 7'd0) begin
      n_sept = 3'd5;
    end else if (sept[3] != 7'd0) begin
      n_sept = 3'd4;
    end else if (sept[2] != 7'd0) begin
      n_sept = 3'd3;
    end else if (sept[1] != 7'd0) begin
      n_sept = 3'd2;
    end else begin
      n_sept = 3'd1;
    end
  end

  always_comb begin
    ev    = '0;
    known = 1'b1;
    pos   = '0;
    unique case (mode)
      mdenc_pkg::MODE_NOTE_OFF: begin
        ev.bytes[0] = mdenc_pkg::STATUS_NOTE_OFF | {4'h0, channel};
        ev.bytes[1] = {1'b0, data_key};
        ev.bytes[2] = 8'h00;
        ev.count    = mdenc_pkg::CntW'(3);
      end
      mdenc_pkg::MODE_NOTE_ON: begin
        ev.bytes[0] = mdenc_pkg::STATUS_NOTE_ON | {4'h0, channel};
        ev.bytes[1] = {1'b0, data_key};
        ev.bytes[2] = {1'b0, data_value[6:0]};
        ev.count    = mdenc_pkg::CntW'(3);
      end
      mdenc_pkg::MODE_CONTROL: begin
        ev.bytes[0] = mdenc_pkg::STATUS_CONTROL | {4'h0, channel};
        ev.bytes[1] = {1'b0, data_key};
        ev.bytes[2] = {1'b0, data_value[6:0]};
        ev.count    = mdenc_pkg::CntW'(3);
      end
      mdenc_pkg::MODE_PROGRAM: begin
        ev.bytes[0] = mdenc_pkg::STATUS_PROGRAM | {4'h0, channel};
        ev.bytes[1] = {1'b0, data_key};
        ev.count    = mdenc_pkg::CntW'(2);
      end
      mdenc_pkg::MODE_PITCH: begin
        ev.bytes[0] = mdenc_pkg::STATUS_PITCH | {4'h0, channel};
        ev.bytes[1] = {1'b0, data_value[6:0]};
        ev.bytes[2] = {1'b0, data_value[13:7]};
        ev.count    = mdenc_pkg::CntW'(3);
      end
      mdenc_pkg::MODE_TEMPO: begin
        ev.bytes[0] = mdenc_pkg::META_PREFIX;
        ev.bytes[1] = mdenc_pkg::TEMPO_TYPE;
        ev.bytes[2] = mdenc_pkg::TEMPO_LEN;
        ev.bytes[3] = data_value[23:16];
        ev.bytes[4] = data_value[15:8];
        ev.bytes[5] = data_value[7:0];
        ev.count    = mdenc_pkg::CntW'(6);
      end
      mdenc_pkg::MODE_VARLEN: begin
        // most significant septet first, continuation bit on all but the last
        for (int k = 0; k < mdenc_pkg::Septets; k++) begin
          pos = n_sept - 3'd1 - 3'(k);
          if (3'(k) < n_sept) begin
            ev.bytes[k] = {(3'(k) != n_sept - 3'd1) & mdenc_pkg::CONT_BIT, sept[pos]};
          end
        end
        ev.count = mdenc_pkg::CntW'(n_sept);
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unused kind is taken and dropped without results
  assign push = start && !full && known;

endmodule

// ===== sv/mdenc_queue.sv =====
module mdenc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mdenc_pkg::event_t     push_ev,
  input  logic                  pop,
  output mdenc_pkg::event_t     head,
  output mdenc_pkg::q_status_t  stat
);

  mdenc_pkg::event_t entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  assign head       = entries[rd_ptr];
  assign stat.empty = (fill == 2'd0);
  assign stat.full  = (fill == 2'd2);

endmodule

// ===== sv/mdenc_back.sv =====
module mdenc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  mdenc_pkg::event_t     head,
  input  mdenc_pkg::q_status_t  stat,
  output logic                  pop,
  output logic                  strobe,
  output logic [7:0]            out_byte,
  output logic                  last
);

  logic [mdenc_pkg::IdxW-1:0] idx;
  logic [mdenc_pkg::IdxW-1:0] idx_next;
  logic                       at_end;

  assign at_end = (mdenc_pkg::CntW'(idx) == head.count - mdenc_pkg::CntW'(1));
  assign pop    = !stat.empty && at_end;

  always_comb begin
    idx_next = idx;
    if (!stat.empty) begin
      idx_next = at_end ? '0 : idx + mdenc_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      idx    <= idx_next;
      strobe <= !stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    out_byte <= head.bytes[idx];
    last     <= at_end;
  end

endmodule

// ===== sv/midi_event_byte_encoder.sv =====
// MIDI event byte encoder
// input channel: an event request (mode, channel, data_key, data_value) is
// transferred at a rising edge with start high and busy low
// result channel: the encoded bytes leave one per cycle on out_byte, each
// for exactly one cycle with strobe high; last marks the final byte of an
// event; the receiver cannot stall, so the output never waits
// path: when the block is empty, an event is written into a queue entry at its
// transfer and its first byte is then registered onto the ports by the serializer
// serializer: it sends one byte per cycle; an event has 2 bytes for program
// change, 3 for the other channel messages, 6 for tempo meta, 1 to 5 for a
// variable-length value; a two-entry queue between classifier and serializer
// lets requests be taken back to back while it has room, busy is high while
// it is full
// mode 7 is taken and gives no bytes
// reset: synchronous, clears the queue and the serializer, no output strobe
module midi_event_byte_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [3:0]  channel,
  input  logic [6:0]  data_key,
  input  logic [31:0] data_value,
  output logic        strobe,
  output logic [7:0]  out_byte,
  output logic        last
);

  mdenc_pkg::event_t    push_ev;
  mdenc_pkg::event_t    head;
  mdenc_pkg::q_status_t q_stat;
  logic                 push;
  logic                 pop;

  assign busy = q_stat.full;

  mdenc_front u_front (
    .start      (start),
    .full       (q_stat.full),
    .mode       (mode),
    .channel    (channel),
    .data_key   (data_key),
    .data_value (data_value),
    .push       (push),
    .ev         (push_ev)
  );

  mdenc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_ev (push_ev),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  mdenc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .stat     (q_stat),
    .pop      (pop),
    .strobe   (strobe),
    .out_byte (out_byte),
    .last     (last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full queue");

  a_unused_dropped: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == mdenc_pkg::MODE_UNUSED) |-> !push)
    else $error("unused mode entered the queue");

  a_strobe_from_queue: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(!q_stat.empty))
    else $error("byte sent with empty queue");

  a_last_pops: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> $past(pop))
    else $error("last byte without queue pop");

endmodule

// ===== verif/tb_midi_event_byte_encoder.sv =====
module tb_midi_event_byte_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 1000;
  localparam int TailCycles = 20;
  localparam int RandomEvents = 175;

  typedef struct packed {
    logic [7:0] value;
    logic       final_byte;
  } midi_byte_t;

  class event_byte_checker;
    midi_byte_t pending_bytes[$];
    int errors = 0;

    // works out the byte string of one event and queues it
    function void note_event(logic [2:0] m, logic [3:0] ch, logic [6:0] key,
                             logic [31:0] v);
      logic [7:0] seq[$];
      logic [7:0] b;
      midi_byte_t e;
      int n;
      case (m)
        mdenc_pkg::MODE_NOTE_OFF:
          seq = '{mdenc_pkg::STATUS_NOTE_OFF | {4'h0, ch}, {1'b0, key}, 8'h00};
        mdenc_pkg::MODE_NOTE_ON:
          seq = '{mdenc_pkg::STATUS_NOTE_ON | {4'h0, ch}, {1'b0, key},
                  {1'b0, v[6:0]}};
        mdenc_pkg::MODE_CONTROL:
          seq = '{mdenc_pkg::STATUS_CONTROL | {4'h0, ch}, {1'b0, key},
                  {1'b0, v[6:0]}};
        mdenc_pkg::MODE_PROGRAM:
          seq = '{mdenc_pkg::STATUS_PROGRAM | {4'h0, ch}, {1'b0, key}};
        mdenc_pkg::MODE_PITCH:
          seq = '{mdenc_pkg::STATUS_PITCH | {4'h0, ch}, {1'b0, v[6:0]},
                  {1'b0, v[13:7]}};
        mdenc_pkg::MODE_TEMPO:
          seq = '{mdenc_pkg::META_PREFIX, mdenc_pkg::TEMPO_TYPE, mdenc_pkg::TEMPO_LEN,
                  v[23:16], v[15:8], v[7:0]};
        mdenc_pkg::MODE_VARLEN: begin
          n = 1;
          while (n < mdenc_pkg::Septets && (v >> (7 * n)) != 0) n++;
          // most significant septet first, continuation on all but the last
          for (int i = n - 1; i >= 0; i--) begin
            b = {(i != 0) ? mdenc_pkg::CONT_BIT : 1'b0, 7'(v >> (7 * i))};
            seq = {seq, b};
          end
        end
        default: ;
      endcase
      foreach (seq[i]) begin
        e.value = seq[i];
        e.final_byte = (i == seq.size() - 1);
        pending_bytes = {pending_bytes, e};
      end
    endfunction

    function void check_byte(logic [7:0] b, logic l);
      midi_byte_t e;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h last %0b", $time, b, l);
        errors++;
      end else begin
        e = pending_bytes.pop_front();
        if (e.value !== b) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, e.value, b);
          errors++;
        end
        if (e.final_byte !== l) begin
          $display("%0t: last expected %0b actual %0b", $time, e.final_byte, l);
          errors++;
        end
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  mode = mdenc_pkg::MODE_NOTE_OFF;
  logic [3:0]  channel = 4'h0;
  logic [6:0]  data_key = 7'h00;
  logic [31:0] data_value = 32'h0;
  logic        busy;
  logic        strobe;
  logic [7:0]  out_byte;
  logic        last;

  event_byte_checker chk = new();
  int idle_cycles = 0;

  midi_event_byte_encoder dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .channel(channel),
    .data_key(data_key),
    .data_value(data_value),
    .strobe(strobe),
    .out_byte(out_byte),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result check and stall watchdog
  always @(posedge clk) begin
    if (!rst && strobe) chk.check_byte(out_byte, last);
    if (!rst && (strobe || (start && !busy))) idle_cycles <= 0;
    else if (!rst) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_request(logic [2:0] m, logic [3:0] ch, logic [6:0] key,
                              logic [31:0] v);
    start <= 1'b1;
    mode <= m;
    channel <= ch;
    data_key <= key;
    data_value <= v;
    do @(posedge clk); while (busy);
    chk.note_event(m, ch, key, v);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic pause_sender(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_random(bit no_gaps);
    logic [2:0] m;
    logic [31:0] v;
    m = ($urandom_range(0, 15) == 0) ? mdenc_pkg::MODE_UNUSED : 3'($urandom_range(0, 6));
    v = $urandom;
    // spread varlen values over every length
    if (m == mdenc_pkg::MODE_VARLEN) v = v >> $urandom_range(0, 31);
    send_request(m, 4'($urandom), 7'($urandom), v);
    pause_sender(no_gaps ? 0 : pick_gap());
  endtask

  initial begin
    int sent;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(mdenc_pkg::MODE_NOTE_OFF, 4'h0, 7'h00, 32'h0);
    send_request(mdenc_pkg::MODE_NOTE_OFF, 4'hF, 7'h7F, 32'hFFFF_FFFF);
    send_request(mdenc_pkg::MODE_NOTE_ON, 4'h0, 7'h00, 32'h0);
    send_request(mdenc_pkg::MODE_NOTE_ON, 4'hF, 7'h7F, 32'hFFFF_FFFF);
    pause_sender(3);
    send_request(mdenc_pkg::MODE_CONTROL, 4'h5, 7'h7F, 32'hFFFF_FF80);
    send_request(mdenc_pkg::MODE_CONTROL, 4'hA, 7'h00, 32'h0000_007F);
    send_request(mdenc_pkg::MODE_PROGRAM, 4'h0, 7'h00, 32'hFFFF_FFFF);
    send_request(mdenc_pkg::MODE_PROGRAM, 4'hF, 7'h7F, 32'h0);
    send_request(mdenc_pkg::MODE_PITCH, 4'h3, 7'h7F, 32'h0);
    send_request(mdenc_pkg::MODE_PITCH, 4'hC, 7'h00, 32'h0000_3FFF);
    send_request(mdenc_pkg::MODE_PITCH, 4'h9, 7'h55, 32'hFFFF_E000);
    send_request(mdenc_pkg::MODE_TEMPO, 4'hF, 7'h7F, 32'h0);
    send_request(mdenc_pkg::MODE_TEMPO, 4'h0, 7'h00, 32'hFFFF_FFFF);
    send_request(mdenc_pkg::MODE_TEMPO, 4'h7, 7'h2A, 32'h0007_A120);
    // unused kind gives no bytes
    send_request(mdenc_pkg::MODE_UNUSED, 4'hF, 7'h7F, 32'hFFFF_FFFF);
    send_request(mdenc_pkg::MODE_VARLEN, 4'h0, 7'h00, 32'h0);
    send_request(mdenc_pkg::MODE_VARLEN, 4'h0, 7'h00, 32'h0000_007F);
    send_request(mdenc_pkg::MODE_VARLEN, 4'h0, 7'h00, 32'h0000_0080);
    send_request(mdenc_pkg::MODE_VARLEN, 4'h0, 7'h00, 32'h0000_3FFF);
    send_request(mdenc_pkg::MODE_VARLEN, 4'h0, 7'h00, 32'h0000_4000);
    send_request(mdenc_pkg::MODE_VARLEN, 4'h0, 7'h00, 32'h001F_FFFF);
    send_request(mdenc_pkg::MODE_VARLEN, 4'h0, 7'h00, 32'h0020_0000);
    send_request(mdenc_pkg::MODE_VARLEN, 4'h0, 7'h00, 32'h0FFF_FFFF);
    send_request(mdenc_pkg::MODE_VARLEN, 4'h0, 7'h00, 32'h1000_0000);
    send_request(mdenc_pkg::MODE_VARLEN, 4'hF, 7'h7F, 32'hFFFF_FFFF);
    send_request(mdenc_pkg::MODE_UNUSED, 4'h0, 7'h00, 32'h0);
    pause_sender(pick_gap());

    sent = 0;
    while (sent < RandomEvents) begin
      // every third stretch of 25 goes back to back
      send_random(((sent / 25) % 3) == 2);
      if (mode != mdenc_pkg::MODE_UNUSED) sent++;
    end

    start <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (chk.errors == 0 && chk.pending() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== midi_event_byte_encoder.f =====
sv/mdenc_pkg.sv
sv/mdenc_front.sv
sv/mdenc_queue.sv
sv/mdenc_back.sv
sv/midi_event_byte_encoder.sv
verif/tb_midi_event_byte_encoder.sv
